[rtl/tbc_pkg.sv]
// Shared types and widths for the triangle barycentric clamp.
// No dependencies; every rtl file imports this package.
package tbc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int WEIGHT_FRAC = 30;
  // Edge vector component, one bit over the coordinate
  localparam int DIFF_W = COORD_WIDTH + 1;
  // Dot product of two edges: product plus two bits of sum growth
  localparam int DOT_W = 2 * DIFF_W + 2;
  // Denominator and weight numerators
  localparam int DEN_W = 2 * DOT_W + 1;
  // Third numerator (denominator minus two numerators)
  localparam int NUM_W = DEN_W + 2;
  // Sum of three clamped numerators
  localparam int SUM_W = NUM_W + 1;
  // Normalized weight, 0 .. 2^WEIGHT_FRAC
  localparam int WGT_W = WEIGHT_FRAC + 1;
  // Weight times coordinate, and the sum of three of them
  localparam int TERM_W = COORD_WIDTH + WGT_W + 1;
  localparam int ACC_W = TERM_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } tbc_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   degenerate;
  } tbc_out_t;

endpackage

[rtl/tbc_mul.sv]
// Signed multiplier built as a row of shift-add cells, one multiplier bit per cell.
// One product per cycle. Uses tbc_pkg only by convention.
module tbc_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import tbc_pkg::*;

  localparam int PW = AW + BW;

  logic [AW-1:0] a_u;
  logic [BW-1:0] b_u;
  logic [AW-1:0] a_mag;
  logic [BW-1:0] b_mag;
  logic [PW-1:0] acc_r [BW];
  logic [AW-1:0] a_r [BW];
  logic [BW-1:0] b_r [BW];
  logic          sgn_r [BW];
  logic [PW-1:0] p_r;

  assign a_u   = a;
  assign b_u   = b;
  assign a_mag = a_u[AW-1] ? (~a_u + AW'(1)) : a_u;
  assign b_mag = b_u[BW-1] ? (~b_u + BW'(1)) : b_u;

  // First cell: take magnitudes, seed the partial sum
  always_ff @(posedge clk) begin
    acc_r[0] <= b_mag[0] ? PW'(a_mag) : '0;
    a_r[0]   <= a_mag;
    b_r[0]   <= b_mag;
    sgn_r[0] <= a_u[AW-1] ^ b_u[BW-1];
  end

  // Each cell adds one shifted partial product and hands on the operands
  for (genvar k = 1; k < BW; k++) begin : g_cell
    always_ff @(posedge clk) begin
      acc_r[k] <= acc_r[k-1] + (b_r[k-1][k] ? (PW'(a_r[k-1]) << k) : '0);
      a_r[k]   <= a_r[k-1];
      b_r[k]   <= b_r[k-1];
      sgn_r[k] <= sgn_r[k-1];
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    p_r <= sgn_r[BW-1] ? (~acc_r[BW-1] + PW'(1)) : acc_r[BW-1];
  end

  assign p = p_r;

endmodule

[rtl/tbc_div.sv]
// Restoring fractional divider as a row of cells, one quotient bit per cell.
// Computes floor(num * 2^(QW-1) / den) for num <= den.
module tbc_div #(
  parameter int SW = 16,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic [SW-1:0] num,
  input  logic [SW-1:0] den,
  output logic [QW-1:0] quo
);
  import tbc_pkg::*;

  logic [SW:0]   rem_r [QW];
  logic [SW-1:0] den_r [QW];
  logic [QW-1:0] q_r [QW];
  logic [SW:0]   r0;
  logic          ge0;

  assign r0  = {1'b0, num};
  assign ge0 = r0 >= {1'b0, den};

  // Integer bit: set only when the numerator equals the divisor
  always_ff @(posedge clk) begin
    rem_r[0] <= ge0 ? (r0 - {1'b0, den}) : r0;
    den_r[0] <= den;
    q_r[0]   <= QW'(ge0);
  end

  for (genvar k = 1; k < QW; k++) begin : g_cell
    logic [SW:0] r2;
    logic        ge;
    assign r2 = {rem_r[k-1][SW-1:0], 1'b0};
    assign ge = r2 >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (r2 - {1'b0, den_r[k-1]}) : r2;
      den_r[k] <= den_r[k-1];
      q_r[k]   <= {q_r[k-1][QW-2:0], ge};
    end
  end

  assign quo = q_r[QW-1];

endmodule

[rtl/tbc_delay.sv]
// Fixed delay line: a row of N registers that shifts every cycle.
// Carries side data alongside the arithmetic cells. Imports tbc_pkg but uses none of it.
module tbc_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  import tbc_pkg::*;

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
  end

  for (genvar k = 1; k < N; k++) begin : g_tap
    always_ff @(posedge clk) begin
      sr_r[k] <= sr_r[k-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

[rtl/triangle_barycentric_clamp.sv]
// Top level of the triangle barycentric clamp.
// Depends on tbc_pkg, tbc_mul, tbc_div and tbc_delay.
//
// Usage:
//   Input channel: drive in_data (three corners and a query point, signed
//   Q16.16) and raise start; a beat is taken at every clock edge with start
//   high and busy low. busy is always low: the block is a free-running
//   pipeline of shift-add and restoring-divide cells and takes a new beat
//   every cycle.
//   Result channel: out_valid is high for exactly one cycle with out_data,
//   once the input beat has passed through every pipeline cell.
//   The pipeline is built from chains of cells: one cell per multiplier bit
//   for the edge dot products, again for the products of 68-bit dot
//   products, one cell per quotient bit in the weight dividers, and one per
//   weight bit in the final blend. Results leave in input order.
//   The receiver cannot stall; every result must be taken when shown.
//   Degenerate triangles (zero denominator) return the point as given with
//   degenerate set.
//   Reset (rst_n low, synchronous) drops every beat in flight; payload
//   registers are not cleared.
module triangle_barycentric_clamp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tbc_pkg::tbc_in_t  in_data,
  output logic              out_valid,
  output tbc_pkg::tbc_out_t out_data
);
  import tbc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int LM1  = DIFF_W + 1;
  localparam int LM2  = DOT_W + 1;
  localparam int LDV  = WGT_W;
  localparam int LM3  = WGT_W + 2;
  localparam int C_E  = 2;
  localparam int C_P1 = C_E + LM1;
  localparam int C_D  = C_P1 + 1;
  localparam int C_P2 = C_D + LM2;
  localparam int C_N  = C_P2 + 1;
  localparam int C_S  = C_N + 1;
  localparam int C_Q  = C_S + LDV;
  localparam int C_W  = C_Q + 1;
  localparam int C_P3 = C_W + LM3;
  localparam int C_T  = C_P3 + 1;
  localparam int C_O  = C_T + 1;
  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << WEIGHT_FRAC;

  function automatic logic signed [DIFF_W-1:0] sub_ext(coord_t p, coord_t q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  // Valid bit for each pipeline cycle
  logic [C_O:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[C_O-1:1], start & ~busy};
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[C_O];

  // Input register, then edge vectors e0 = c - a, e1 = b - a, e2 = p - a
  tbc_in_t in_r;
  logic signed [DIFF_W-1:0] e0_r [3];
  logic signed [DIFF_W-1:0] e1_r [3];
  logic signed [DIFF_W-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    in_r    <= in_data;
    e0_r[0] <= sub_ext(in_r.corner_c_x, in_r.corner_a_x);
    e0_r[1] <= sub_ext(in_r.corner_c_y, in_r.corner_a_y);
    e0_r[2] <= sub_ext(in_r.corner_c_z, in_r.corner_a_z);
    e1_r[0] <= sub_ext(in_r.corner_b_x, in_r.corner_a_x);
    e1_r[1] <= sub_ext(in_r.corner_b_y, in_r.corner_a_y);
    e1_r[2] <= sub_ext(in_r.corner_b_z, in_r.corner_a_z);
    e2_r[0] <= sub_ext(in_r.point_x, in_r.corner_a_x);
    e2_r[1] <= sub_ext(in_r.point_y, in_r.corner_a_y);
    e2_r[2] <= sub_ext(in_r.point_z, in_r.corner_a_z);
  end

  // Dot products d00, d01, d02, d11, d12: three component products each
  logic signed [DIFF_W-1:0]   ma [5][3];
  logic signed [DIFF_W-1:0]   mb [5][3];
  logic signed [2*DIFF_W-1:0] prod1 [5][3];
  logic signed [DOT_W-1:0]    d_r [5];

  for (genvar k = 0; k < 3; k++) begin : g_ops
    assign ma[0][k] = e0_r[k];
    assign mb[0][k] = e0_r[k];
    assign ma[1][k] = e0_r[k];
    assign mb[1][k] = e1_r[k];
    assign ma[2][k] = e0_r[k];
    assign mb[2][k] = e2_r[k];
    assign ma[3][k] = e1_r[k];
    assign mb[3][k] = e1_r[k];
    assign ma[4][k] = e1_r[k];
    assign mb[4][k] = e2_r[k];
  end

  for (genvar j = 0; j < 5; j++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_cmp
      tbc_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul (
        .clk (clk),
        .a   (ma[j][k]),
        .b   (mb[j][k]),
        .p   (prod1[j][k])
      );
    end
    always_ff @(posedge clk) begin
      d_r[j] <= DOT_W'(prod1[j][0]) + DOT_W'(prod1[j][1]) + DOT_W'(prod1[j][2]);
    end
  end

  // Second-level products: den = d00*d11 - d01^2, nu and nv numerators
  logic signed [DOT_W-1:0]   m2a [6];
  logic signed [DOT_W-1:0]   m2b [6];
  logic signed [2*DOT_W-1:0] prod2 [6];

  assign m2a[0] = d_r[0]; assign m2b[0] = d_r[3];
  assign m2a[1] = d_r[1]; assign m2b[1] = d_r[1];
  assign m2a[2] = d_r[3]; assign m2b[2] = d_r[2];
  assign m2a[3] = d_r[1]; assign m2b[3] = d_r[4];
  assign m2a[4] = d_r[0]; assign m2b[4] = d_r[4];
  assign m2a[5] = d_r[1]; assign m2b[5] = d_r[2];

  for (genvar j = 0; j < 6; j++) begin : g_den
    tbc_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul (
      .clk (clk),
      .a   (m2a[j]),
      .b   (m2b[j]),
      .p   (prod2[j])
    );
  end

  logic signed [DEN_W-1:0] den_r;
  logic signed [DEN_W-1:0] nu_r;
  logic signed [DEN_W-1:0] nv_r;

  always_ff @(posedge clk) begin
    den_r <= DEN_W'(prod2[0]) - DEN_W'(prod2[1]);
    nu_r  <= DEN_W'(prod2[2]) - DEN_W'(prod2[3]);
    nv_r  <= DEN_W'(prod2[4]) - DEN_W'(prod2[5]);
  end

  // Clamp numerators at zero and form their sum
  logic signed [NUM_W-1:0] nw;
  logic [SUM_W-1:0] nu_c;
  logic [SUM_W-1:0] nv_c;
  logic [SUM_W-1:0] nw_c;
  logic [SUM_W-1:0] nuc_r;
  logic [SUM_W-1:0] nvc_r;
  logic [SUM_W-1:0] s_r;
  logic             deg_s_r;

  assign nw   = NUM_W'(den_r) - NUM_W'(nu_r) - NUM_W'(nv_r);
  assign nu_c = nu_r[DEN_W-1] ? '0 : SUM_W'(nu_r);
  assign nv_c = nv_r[DEN_W-1] ? '0 : SUM_W'(nv_r);
  assign nw_c = nw[NUM_W-1] ? '0 : SUM_W'(nw);

  always_ff @(posedge clk) begin
    nuc_r   <= nu_c;
    nvc_r   <= nv_c;
    s_r     <= nu_c + nv_c + nw_c;
    deg_s_r <= (den_r == '0);
  end

  // Normalized weights
  logic [WGT_W-1:0] u_q;
  logic [WGT_W-1:0] v_q;
  logic             deg_q;

  tbc_div #(.SW(SUM_W), .QW(WGT_W)) u_div_u (
    .clk (clk),
    .num (nuc_r),
    .den (s_r),
    .quo (u_q)
  );

  tbc_div #(.SW(SUM_W), .QW(WGT_W)) u_div_v (
    .clk (clk),
    .num (nvc_r),
    .den (s_r),
    .quo (v_q)
  );

  tbc_delay #(.W(1), .N(LDV)) u_deg_q (
    .clk (clk),
    .d   (deg_s_r),
    .q   (deg_q)
  );

  logic signed [WGT_W:0] wa_r;
  logic signed [WGT_W:0] wb_r;
  logic signed [WGT_W:0] wc_r;

  always_ff @(posedge clk) begin
    wa_r <= $signed({1'b0, ONE - u_q - v_q});
    wb_r <= $signed({1'b0, v_q});
    wc_r <= $signed({1'b0, u_q});
  end

  // Corners held until the weights are ready
  tbc_in_t crn_d;

  tbc_delay #(.W($bits(tbc_in_t)), .N(C_W - 1)) u_crn (
    .clk (clk),
    .d   (in_r),
    .q   (crn_d)
  );

  // Blend: weight times corner for every axis
  coord_t cc [3][3];
  logic signed [WGT_W:0]    ww [3];
  logic signed [TERM_W-1:0] prod3 [3][3];
  logic signed [ACC_W-1:0]  t_r [3];

  assign ww[0] = wa_r;
  assign ww[1] = wb_r;
  assign ww[2] = wc_r;
  assign cc[0][0] = crn_d.corner_a_x;
  assign cc[0][1] = crn_d.corner_a_y;
  assign cc[0][2] = crn_d.corner_a_z;
  assign cc[1][0] = crn_d.corner_b_x;
  assign cc[1][1] = crn_d.corner_b_y;
  assign cc[1][2] = crn_d.corner_b_z;
  assign cc[2][0] = crn_d.corner_c_x;
  assign cc[2][1] = crn_d.corner_c_y;
  assign cc[2][2] = crn_d.corner_c_z;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_crn
      tbc_mul #(.AW(CW), .BW(WGT_W + 1)) u_mul (
        .clk (clk),
        .a   (cc[j][k]),
        .b   (ww[j]),
        .p   (prod3[j][k])
      );
    end
    always_ff @(posedge clk) begin
      t_r[k] <= ACC_W'(prod3[0][k]) + ACC_W'(prod3[1][k]) + ACC_W'(prod3[2][k]);
    end
  end

  // Point and flag aligned with the blended sums
  logic [3*CW-1:0] pt_d;
  logic            deg_t;

  tbc_delay #(.W(3*CW), .N(C_T - C_W)) u_pt (
    .clk (clk),
    .d   ({crn_d.point_x, crn_d.point_y, crn_d.point_z}),
    .q   (pt_d)
  );

  tbc_delay #(.W(1), .N(C_T - C_Q)) u_deg_t (
    .clk (clk),
    .d   (deg_q),
    .q   (deg_t)
  );

  // Drop the weight fraction, truncating toward zero
  logic [ACC_W-1:0] t_mag [3];
  logic [ACC_W-1:0] t_sh [3];
  logic [ACC_W-1:0] t_res [3];

  for (genvar k = 0; k < 3; k++) begin : g_trunc
    logic [ACC_W-1:0] t_u;
    assign t_u      = t_r[k];
    assign t_mag[k] = t_u[ACC_W-1] ? (~t_u + ACC_W'(1)) : t_u;
    assign t_sh[k]  = t_mag[k] >> WEIGHT_FRAC;
    assign t_res[k] = t_u[ACC_W-1] ? (~t_sh[k] + ACC_W'(1)) : t_sh[k];
  end

  tbc_out_t out_r;

  always_ff @(posedge clk) begin
    out_r.degenerate <= deg_t;
    if (deg_t) begin
      out_r.out_x <= pt_d[3*CW-1:2*CW];
      out_r.out_y <= pt_d[2*CW-1:CW];
      out_r.out_z <= pt_d[CW-1:0];
    end else begin
      out_r.out_x <= t_res[0][CW-1:0];
      out_r.out_y <= t_res[1][CW-1:0];
      out_r.out_z <= t_res[2][CW-1:0];
    end
  end

  assign out_data = out_r;

  // Every beat taken comes out exactly once, after the fixed latency
  a_beat_out : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##C_O out_valid)
    else $error("accepted beat did not produce a result");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, C_O))
    else $error("result without a matching input beat");

  // Normalized weights never exceed one in total
  a_weight_sum : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[C_Q] && !deg_q) |-> ((WGT_W + 1)'(u_q) + (WGT_W + 1)'(v_q) <= (WGT_W + 1)'(ONE)))
    else $error("weights sum above one");

endmodule
